// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// clocked assertion, also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/wstd_pkg.sv =====
// ----------------------------------------------------------------------------
// wstd_pkg
// shared constants, types and command structs of the sigma threshold detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wstd_pkg;

    localparam int COUNT_BITS_DEF  = 20;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int FRAC_BITS  = 16;
    localparam int MEAN_W     = 32;
    localparam int ROOT_W     = 32;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int M2_W       = 64;
    localparam int VAR_W      = 44;
    localparam int VAR_SHIFT  = 20;
    localparam int PROD_SHIFT = 20;
    localparam int KC_W       = 16;
    localparam int KC_FRAC    = 12;
    localparam int KCS_W      = KC_W + ROOT_W;

    localparam logic [KC_W-1:0] KC_RESET = 16'd5902;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_KC_GAIN = 2'd0;

    localparam int M_TDATA_W = 72;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV1_WAIT,
        ST_DIFF,
        ST_MUL,
        ST_M2,
        ST_DIV2,
        ST_DIV2_WAIT,
        ST_SQRT_WAIT,
        ST_THR,
        ST_DONE
    } state_t;

    typedef enum logic {
        DIV_MEAN,
        DIV_VAR
    } div_sel_t;

    typedef struct packed {
        logic       load;
        logic       div_start;
        div_sel_t   div_sel;
        logic       mean_upd;
        logic       diff_upd;
        logic       mul_step;
        logic [1:0] mul_idx;
        logic       m2_upd;
        logic       sqrt_start;
        logic       thr_mul;
        logic       result;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic n_ge2;
    } stat_t;

endpackage

// ===== rtl/wstd_div.sv =====
// ----------------------------------------------------------------------------
// wstd_div
// restoring unsigned divider, one quotient bit per cycle, numerator msb-aligned
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wstd_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 20,
    parameter int LEN_W = $clog2(NUM_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [LEN_W-1:0] len,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   r_sh;
    logic [DEN_W:0]   r_diff;
    logic             ge;

    assign r_sh   = {rem_reg, q_reg[NUM_W-1]};
    assign r_diff = r_sh - {1'b0, den_reg};
    assign ge     = (r_sh >= {1'b0, den_reg});

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = num;
            rem_next  = '0;
            cnt_next  = len;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[NUM_W-2:0], ge};
            rem_next = ge ? r_diff[DEN_W-1:0] : r_sh[DEN_W-1:0];
            cnt_next = cnt_reg - LEN_W'(1);
            if (cnt_reg == LEN_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;

endmodule

// ===== rtl/wstd_sqrt.sv =====
// ----------------------------------------------------------------------------
// wstd_sqrt
// digit-by-digit integer square root, one root bit per cycle, floor result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wstd_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [wstd_pkg::RAD_W-1:0]  rad,
    output logic [wstd_pkg::ROOT_W-1:0] root,
    output logic                        done
);

    localparam int RW    = wstd_pkg::ROOT_W;
    localparam int CNT_W = $clog2(RW + 1);

    logic [wstd_pkg::RAD_W-1:0] rad_reg, rad_next;
    logic [RW-1:0]              root_reg, root_next;
    logic [RW+1:0]              rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    logic [RW+3:0] r_diff;
    logic          ge;

    assign rem_sh = {rem_reg, rad_reg[wstd_pkg::RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign r_diff = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_comb begin
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = rad;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = CNT_W'(RW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[wstd_pkg::RAD_W-3:0], 2'b00};
            root_next = {root_reg[RW-2:0], ge};
            rem_next  = ge ? r_diff[RW+1:0] : rem_sh[RW+1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ===== rtl/wstd_datapath.sv =====
// ----------------------------------------------------------------------------
// wstd_datapath
// running count, mean and deviation sum, divider, root and threshold compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wstd_datapath #(
    parameter int COUNT_BITS  = wstd_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = wstd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  wstd_pkg::cmd_t                     cmd,
    output wstd_pkg::stat_t                    stat,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    input  logic [wstd_pkg::KC_W-1:0]          kc_gain,
    output logic                               alert,
    output logic signed [wstd_pkg::MEAN_W-1:0] mean_out,
    output logic [wstd_pkg::ROOT_W-1:0]        sigma_out
);

    localparam int X_W    = SAMPLE_BITS + wstd_pkg::FRAC_BITS;
    localparam int D_W    = ((X_W > wstd_pkg::MEAN_W) ? X_W : wstd_pkg::MEAN_W) + 1;
    localparam int H_W    = (D_W + 1) / 2;
    localparam int ACC_W  = 4 * H_W;
    localparam int DIV_W  = wstd_pkg::M2_W;
    localparam int LEN_W  = $clog2(DIV_W + 1);
    localparam int TH_A   = D_W + wstd_pkg::KC_FRAC;
    localparam int TH_W   = ((TH_A > wstd_pkg::KCS_W) ? TH_A : wstd_pkg::KCS_W) + 1;
    localparam int MW     = wstd_pkg::MEAN_W;
    localparam int M2W    = wstd_pkg::M2_W;

    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic signed [D_W:0] MEAN_HI =
        {{(D_W + 1 - MW){1'b0}}, 1'b0, {(MW - 1){1'b1}}};
    localparam logic signed [D_W:0] MEAN_LO =
        {{(D_W + 2 - MW){1'b1}}, {(MW - 1){1'b0}}};
    localparam logic [wstd_pkg::VAR_W-1:0] VAR_MAX = {wstd_pkg::VAR_W{1'b1}};

    logic signed [X_W-1:0]     x_reg;
    logic [COUNT_BITS-1:0]     count_reg, count_next;
    logic signed [MW-1:0]      mean_reg;
    logic [M2W-1:0]            m2_reg;
    logic                      d1_neg_reg;
    logic [D_W-1:0]            mag1_reg;
    logic signed [D_W-1:0]     d2_reg;
    logic [D_W-1:0]            mag2_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [wstd_pkg::KCS_W-1:0] kcs_reg;
    logic                      alert_reg;
    logic signed [MW-1:0]      mean_out_reg;
    logic [wstd_pkg::ROOT_W-1:0] sigma_out_reg;

    logic signed [X_W-1:0]     x_in;
    logic signed [D_W-1:0]     d1;
    logic signed [D_W-1:0]     d2;
    logic [DIV_W-1:0]          div_num;
    logic [COUNT_BITS-1:0]     div_den;
    logic [LEN_W-1:0]          div_len;
    logic [DIV_W-1:0]          div_q;
    logic                      div_done;
    logic signed [D_W-1:0]     q_signed;
    logic signed [D_W:0]       mean_sum;
    logic signed [MW-1:0]      mean_clamped;
    logic [2*H_W-1:0]          a_pad, b_pad;
    logic [H_W-1:0]            a_part, b_part;
    logic [2*H_W-1:0]          pp;
    logic [ACC_W-1:0]          pp_shifted;
    logic [M2W-1:0]            prod;
    logic [M2W:0]              m2_add;
    logic                      m2_sub;
    logic [M2W-1:0]            m2_new;
    logic [wstd_pkg::VAR_W-1:0] var_clamped;
    logic [wstd_pkg::RAD_W-1:0] rad;
    logic [wstd_pkg::ROOT_W-1:0] root;
    logic                      sqrt_done;
    logic signed [TH_W-1:0]    th_lhs, th_rhs;
    logic                      n_ge2;

    assign n_ge2 = (count_reg >= COUNT_BITS'(2));
    assign x_in  = {sample, {wstd_pkg::FRAC_BITS{1'b0}}};
    assign count_next = (count_reg == CMAX) ? count_reg : count_reg + COUNT_BITS'(1);
    assign d1 = D_W'(x_in) - D_W'(mean_reg);
    assign d2 = D_W'(x_reg) - D_W'(mean_reg);

    // shared divider: mean step, then variance
    always_comb begin
        if (cmd.div_sel == wstd_pkg::DIV_MEAN) begin
            div_num = {mag1_reg, {(DIV_W - D_W){1'b0}}};
            div_den = count_reg;
            div_len = LEN_W'(D_W);
        end else begin
            div_num = m2_reg;
            div_den = count_reg - COUNT_BITS'(1);
            div_len = LEN_W'(DIV_W);
        end
    end

    wstd_div #(
        .NUM_W (DIV_W),
        .DEN_W (COUNT_BITS),
        .LEN_W (LEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .len     (div_len),
        .quo     (div_q),
        .done    (div_done)
    );

    // quotient truncates toward zero, mean clamped to its range
    always_comb begin
        q_signed = d1_neg_reg ? -$signed(div_q[D_W-1:0]) : $signed(div_q[D_W-1:0]);
        mean_sum = (D_W + 1)'(mean_reg) + (D_W + 1)'(q_signed);
        if (mean_sum > MEAN_HI) begin
            mean_clamped = MEAN_HI[MW-1:0];
        end else if (mean_sum < MEAN_LO) begin
            mean_clamped = MEAN_LO[MW-1:0];
        end else begin
            mean_clamped = mean_sum[MW-1:0];
        end
    end

    // 2x2 split multiply of deviation magnitudes
    always_comb begin
        a_pad  = (2 * H_W)'(mag1_reg);
        b_pad  = (2 * H_W)'(mag2_reg);
        a_part = cmd.mul_idx[1] ? a_pad[2*H_W-1:H_W] : a_pad[H_W-1:0];
        b_part = cmd.mul_idx[0] ? b_pad[2*H_W-1:H_W] : b_pad[H_W-1:0];
        pp     = a_part * b_part;
        case (cmd.mul_idx)
            2'b00:   pp_shifted = ACC_W'(pp);
            2'b01,
            2'b10:   pp_shifted = ACC_W'(pp) << H_W;
            2'b11:   pp_shifted = ACC_W'(pp) << (2 * H_W);
            default: pp_shifted = ACC_W'(pp);
        endcase
    end

    // deviation sum, saturating add or floored subtract
    always_comb begin
        prod   = M2W'(acc_reg[ACC_W-1:wstd_pkg::PROD_SHIFT]);
        m2_sub = (d1_neg_reg != d2_reg[D_W-1]) && (mag1_reg != '0) && (mag2_reg != '0);
        m2_add = {1'b0, m2_reg} + {1'b0, prod};
        if (m2_sub) begin
            m2_new = (m2_reg > prod) ? m2_reg - prod : '0;
        end else begin
            m2_new = m2_add[M2W] ? {M2W{1'b1}} : m2_add[M2W-1:0];
        end
    end

    assign var_clamped = (|div_q[DIV_W-1:wstd_pkg::VAR_W]) ? VAR_MAX
                                                         : div_q[wstd_pkg::VAR_W-1:0];
    assign rad = {var_clamped, {wstd_pkg::VAR_SHIFT{1'b0}}};

    wstd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .rad     (rad),
        .root    (root),
        .done    (sqrt_done)
    );

    // exact compare: d2 * 2^12 against kc * sigma
    assign th_lhs = {{(TH_W - TH_A){d2_reg[D_W-1]}}, d2_reg, {wstd_pkg::KC_FRAC{1'b0}}};
    assign th_rhs = {{(TH_W - wstd_pkg::KCS_W){1'b0}}, kcs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            mean_reg  <= '0;
            m2_reg    <= '0;
        end else begin
            if (cmd.load) begin
                count_reg <= count_next;
            end
            if (cmd.mean_upd) begin
                mean_reg <= mean_clamped;
            end
            if (cmd.m2_upd) begin
                m2_reg <= m2_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg      <= x_in;
            d1_neg_reg <= d1[D_W-1];
            mag1_reg   <= d1[D_W-1] ? D_W'(-d1) : D_W'(d1);
            acc_reg    <= '0;
        end
        if (cmd.diff_upd) begin
            d2_reg   <= d2;
            mag2_reg <= d2[D_W-1] ? D_W'(-d2) : D_W'(d2);
        end
        if (cmd.mul_step) begin
            acc_reg <= acc_reg + pp_shifted;
        end
        if (cmd.thr_mul) begin
            kcs_reg <= kc_gain * root;
        end
        if (cmd.result) begin
            alert_reg     <= n_ge2 && (th_lhs > th_rhs);
            mean_out_reg  <= mean_reg;
            sigma_out_reg <= n_ge2 ? root : '0;
        end
    end

    assign stat.div_done  = div_done;
    assign stat.sqrt_done = sqrt_done;
    assign stat.n_ge2     = n_ge2;

    assign alert     = alert_reg;
    assign mean_out  = mean_out_reg;
    assign sigma_out = sigma_out_reg;

endmodule

// ===== rtl/wstd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wstd_ctrl
// sequencer for one item: update, divide, multiply, divide, root, compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wstd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output wstd_pkg::cmd_t  cmd,
    input  wstd_pkg::stat_t stat
);

    wstd_pkg::state_t state_reg, state_next;
    logic [1:0]       mul_cnt_reg, mul_cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wstd_pkg::ST_IDLE;
            mul_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mul_cnt_reg  <= mul_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        mul_cnt_next = mul_cnt_reg;
        cmd          = '0;
        cmd.div_sel  = wstd_pkg::DIV_MEAN;
        s_tready     = 1'b0;
        case (state_reg)
            wstd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = wstd_pkg::ST_DIV1;
                end
            end
            wstd_pkg::ST_DIV1: begin
                cmd.div_start = 1'b1;
                state_next    = wstd_pkg::ST_DIV1_WAIT;
            end
            wstd_pkg::ST_DIV1_WAIT: begin
                if (stat.div_done) begin
                    cmd.mean_upd = 1'b1;
                    state_next   = wstd_pkg::ST_DIFF;
                end
            end
            wstd_pkg::ST_DIFF: begin
                cmd.diff_upd = 1'b1;
                mul_cnt_next = '0;
                state_next   = wstd_pkg::ST_MUL;
            end
            wstd_pkg::ST_MUL: begin
                cmd.mul_step = 1'b1;
                cmd.mul_idx  = mul_cnt_reg;
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd3) begin
                    state_next = wstd_pkg::ST_M2;
                end
            end
            wstd_pkg::ST_M2: begin
                cmd.m2_upd = 1'b1;
                state_next = stat.n_ge2 ? wstd_pkg::ST_DIV2 : wstd_pkg::ST_DONE;
            end
            wstd_pkg::ST_DIV2: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = wstd_pkg::DIV_VAR;
                state_next    = wstd_pkg::ST_DIV2_WAIT;
            end
            wstd_pkg::ST_DIV2_WAIT: begin
                if (stat.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = wstd_pkg::ST_SQRT_WAIT;
                end
            end
            wstd_pkg::ST_SQRT_WAIT: begin
                if (stat.sqrt_done) begin
                    state_next = wstd_pkg::ST_THR;
                end
            end
            wstd_pkg::ST_THR: begin
                cmd.thr_mul = 1'b1;
                state_next  = wstd_pkg::ST_DONE;
            end
            wstd_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.result = 1'b1;
                    state_next = wstd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wstd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.result) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== rtl/welford_sigma_threshold_detector.sv =====
// ----------------------------------------------------------------------------
// welford_sigma_threshold_detector
// running mean and sigma of a sample stream with a k-sigma alert
//
// s_ channel: one signed sample per item; m_ channel: one result per item
// carrying alert, the running mean (Q15.16) and sigma (Q16.16).
// apb port: kc_gain (Q4.12) at address 0, to be written only while idle;
// the user must keep to this, the block itself does not enforce it.
// an item passes the mean divide (SAMPLE_BITS + 17 quotient bits, at least
// 33), the deviation multiply, the 64-bit variance divide in the bit-serial
// divider and the 32-step root unit; the first item after reset skips the
// variance and root.
// s_tready is high only while the sequencer is idle, so a new sample is not
// taken until the previous item is finished; the next sample is taken
// while the previous result still waits in the output register.
// a stalled receiver holds the result; the block finishes the next item and
// waits until the output register is free.
// reset clears count, mean, deviation sum and kc_gain to 1.441, and empties
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module welford_sigma_threshold_detector #(
    parameter int COUNT_BITS  = wstd_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = wstd_pkg::SAMPLE_BITS_DEF,
    parameter int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_TDATA_W-1:0]            s_tdata,
    // alert, mean_out, sigma_out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wstd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wstd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wstd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wstd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int RES_W = 1 + wstd_pkg::MEAN_W + wstd_pkg::ROOT_W;

    logic [wstd_pkg::KC_W-1:0]          kc_reg;
    wstd_pkg::cmd_t                     cmd;
    wstd_pkg::stat_t                    stat;
    logic                               alert;
    logic signed [wstd_pkg::MEAN_W-1:0] mean_out;
    logic [wstd_pkg::ROOT_W-1:0]        sigma_out;

    assign pready = 1'b1;
    assign prdata = (paddr == wstd_pkg::ADDR_KC_GAIN) ? wstd_pkg::APB_DATA_W'(kc_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kc_reg <= wstd_pkg::KC_RESET;
        end else if (psel && penable && pwrite && pready) begin
            kc_reg <= pwdata[wstd_pkg::KC_W-1:0];
        end
    end

    wstd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    wstd_datapath #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .sample    ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .kc_gain   (kc_reg),
        .alert     (alert),
        .mean_out  (mean_out),
        .sigma_out (sigma_out)
    );

    assign m_tdata = {{(wstd_pkg::M_TDATA_W - RES_W){1'b0}}, sigma_out, mean_out, alert};

endmodule

// ===== rtl/wstd_checker.sv =====
// ----------------------------------------------------------------------------
// wstd_checker
// port-level checks of the detector, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wstd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [wstd_pkg::M_TDATA_W-1:0] m_tdata
);

    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    `ASSERT_CLK(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)

    `ASSERT_CLK(a_result_while_busy, aclk, aresetn,
        $rose(m_tvalid) |-> $past(!s_tready))

endmodule

bind welford_sigma_threshold_detector wstd_checker u_wstd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/welford_sigma_threshold_detector_tb.sv =====
// ----------------------------------------------------------------------------
// welford_sigma_threshold_detector_tb
// self-checking bench for the running mean / sigma k-sigma detector
//
// drives signed samples into the s_ channel with random gaps and checks each
// m_ item field by field against a bit-true running-statistics predictor.
// kc_gain is reprogrammed over apb between phases, always once the pipeline
// is drained, and read back. the output side stalls at random and twice
// holds off for a long stretch to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module welford_sigma_threshold_detector_tb;

    localparam int SAMPLE_W        = wstd_pkg::SAMPLE_BITS_DEF;
    localparam int CNT_W           = wstd_pkg::COUNT_BITS_DEF;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int NUM_PHASES      = 5;
    localparam int STALL_LIMIT     = 3000;
    localparam int LONG_HOLD       = 600;
    localparam int ALERT_BIT       = 0;
    localparam int MEAN_LSB        = 1;
    localparam int SIGMA_LSB       = MEAN_LSB + wstd_pkg::MEAN_W;

    // running statistics predictor and queue of expected items
    class sigma_alert_board;
        typedef struct {
            bit          alert;
            logic [31:0] mean;
            logic [31:0] sigma;
        } stats_t;

        stats_t                      pending_stats[$];
        bit [CNT_W-1:0]              seen_count;
        longint                      mean_q16;
        bit [wstd_pkg::M2_W-1:0]     dev_sum;
        bit [wstd_pkg::KC_W-1:0]     gain;
        int                          errors;
        int                          checked;
        int                          alerts;

        function new();
            seen_count = '0;
            mean_q16   = 0;
            dev_sum    = '0;
            gain       = wstd_pkg::KC_RESET;
            errors     = 0;
            checked    = 0;
            alerts     = 0;
        endfunction

        function bit [63:0] root(bit [63:0] v);
            bit [63:0] r;
            bit [63:0] t;
            r = '0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        function void add_sample(logic [SAMPLE_W-1:0] smp);
            longint        x, d1, d2, nn, lhs, rhs;
            bit [63:0]     mag1, mag2, prod, var_q12, sigma;
            bit [127:0]    full;
            bit [64:0]     sum65;
            stats_t        e;
            x = longint'($signed(smp)) * 65536;
            if (seen_count != '1) seen_count++;
            nn = seen_count;
            d1 = x - mean_q16;
            mean_q16 = mean_q16 + d1 / nn;
            if (mean_q16 > 64'sd2147483647) mean_q16 = 64'sd2147483647;
            if (mean_q16 < -64'sd2147483648) mean_q16 = -64'sd2147483648;
            d2 = x - mean_q16;
            mag1 = (d1 < 0) ? -d1 : d1;
            mag2 = (d2 < 0) ? -d2 : d2;
            full = {64'd0, mag1} * {64'd0, mag2};
            prod = (full[127:84] != '0) ? '1 : full[83:20];
            if ((d1 < 0) == (d2 < 0) || d1 == 0 || d2 == 0) begin
                sum65 = {1'b0, dev_sum} + {1'b0, prod};
                dev_sum = sum65[64] ? '1 : sum65[63:0];
            end else begin
                dev_sum = (dev_sum > prod) ? dev_sum - prod : '0;
            end
            e.alert = 1'b0;
            sigma = '0;
            if (seen_count >= 2) begin
                var_q12 = dev_sum / (seen_count - 1);
                if (var_q12 > (64'd1 << wstd_pkg::VAR_W) - 1)
                    var_q12 = (64'd1 << wstd_pkg::VAR_W) - 1;
                sigma = root(var_q12 << wstd_pkg::VAR_SHIFT);
                lhs = x * 4096;
                rhs = mean_q16 * 4096 + longint'(gain * sigma);
                e.alert = (lhs > rhs);
            end
            e.mean  = mean_q16[31:0];
            e.sigma = sigma[31:0];
            pending_stats.push_back(e);
        endfunction

        function void check_result(logic [wstd_pkg::M_TDATA_W-1:0] td);
            stats_t e;
            if (pending_stats.size() == 0) begin
                $error("result item with no sample pending: %h", td);
                errors++;
                return;
            end
            e = pending_stats.pop_front();
            checked++;
            if (e.alert) alerts++;
            if (td[ALERT_BIT] !== e.alert) begin
                $error("alert: expected %0d, got %0d", e.alert, td[ALERT_BIT]);
                errors++;
            end
            if (td[MEAN_LSB +: wstd_pkg::MEAN_W] !== e.mean) begin
                $error("mean_out: expected %0d, got %0d",
                       $signed(e.mean), $signed(td[MEAN_LSB +: wstd_pkg::MEAN_W]));
                errors++;
            end
            if (td[SIGMA_LSB +: wstd_pkg::ROOT_W] !== e.sigma) begin
                $error("sigma_out: expected %0d, got %0d",
                       e.sigma, td[SIGMA_LSB +: wstd_pkg::ROOT_W]);
                errors++;
            end
        endfunction
    endclass

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [SAMPLE_W-1:0]             s_tdata  = '0;      // sample
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [wstd_pkg::M_TDATA_W-1:0]  m_tdata;            // alert, mean_out, sigma_out
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [wstd_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [wstd_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [wstd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    sigma_alert_board board = new();
    bit               burst = 1'b0;
    int               gains_used = 1;

    welford_sigma_threshold_detector dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        board.add_sample(smp);
    endtask

    task automatic apb_write(input logic [wstd_pkg::APB_ADDR_W-1:0] addr,
                             input logic [wstd_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [wstd_pkg::APB_ADDR_W-1:0] addr,
                            output logic [wstd_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_gain(input logic [wstd_pkg::KC_W-1:0] gain);
        logic [wstd_pkg::APB_DATA_W-1:0] rd;
        apb_read(wstd_pkg::ADDR_KC_GAIN, rd);
        if (rd !== wstd_pkg::APB_DATA_W'(gain)) begin
            $error("kc_gain: expected %0d, got %0d", gain, rd);
            board.errors++;
        end
    endtask

    task automatic set_gain(input logic [wstd_pkg::KC_W-1:0] gain);
        apb_write(wstd_pkg::ADDR_KC_GAIN, wstd_pkg::APB_DATA_W'(gain));
        board.gain = gain;
        gains_used++;
        @(posedge aclk);
        check_gain(gain);
    endtask

    task automatic drain();
        while (board.pending_stats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // output side: random stalls, two long hold-offs to back the block up
    initial begin : sink
        int hold;
        int got;
        got = 0;
        wait (aresetn);
        forever begin
            hold = burst ? 0 : $urandom_range(0, 10);
            if (got == 150 || got == 700) hold = LONG_HOLD;
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            board.check_result(m_tdata);
            got++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [SAMPLE_W-1:0]         directed[20];
        logic [wstd_pkg::KC_W-1:0]   gain_plan[NUM_PHASES];
        int                          base, spread, pick, val;

        directed = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                     16'h0000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA,
                     16'd100,  16'd100,  16'd100,  16'd100,  16'd100,
                     16'd100,  16'd30000, -16'sd30000, 16'h0000, 16'h0000};
        gain_plan = '{16'd0, 16'hFFFF, 16'd4096, 16'd0, 16'd1};
        gain_plan[3] = wstd_pkg::KC_W'($urandom_range(0, 65535));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_gain(wstd_pkg::KC_RESET);

        // first sample, full-scale swings, bit patterns, flat run then spikes
        foreach (directed[i]) send_sample(directed[i], $urandom_range(0, 10));
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            set_gain(gain_plan[ph]);
            base = int'($urandom_range(0, 40000)) - 20000;
            case ($urandom_range(0, 3))
                0: spread = 3;
                1: spread = 60;
                2: spread = 900;
                default: spread = 6000;
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 60 == 0) burst = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    val = base + int'($urandom_range(0, 2 * spread)) - spread;
                else if (pick < 80)
                    val = base + int'($urandom_range(500, 25000));
                else if (pick < 85)
                    val = base - int'($urandom_range(500, 25000));
                else if (pick < 95)
                    val = int'($urandom_range(0, 65535)) - 32768;
                else
                    val = $urandom_range(0, 1) ? 32767 : -32768;
                if (val > 32767) val = 32767;
                if (val < -32768) val = -32768;
                send_sample(val[SAMPLE_W-1:0], burst ? 0 : $urandom_range(0, 10));
            end
            s_tvalid <= 1'b0;
        end
        burst = 1'b0;

        drain();
        repeat (200) @(posedge aclk);
        $display("checked %0d result items, %0d with alert raised, over %0d kc_gain settings",
                 board.checked, board.alerts, gains_used);
        $display("random gaps on both sides, two long output hold-offs, drained pauses");
        if (board.errors == 0 && board.pending_stats.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wstd_pkg.sv
rtl/wstd_div.sv
rtl/wstd_sqrt.sv
rtl/wstd_datapath.sv
rtl/wstd_ctrl.sv
rtl/welford_sigma_threshold_detector.sv
rtl/wstd_checker.sv
sim/welford_sigma_threshold_detector_tb.sv
